FILE: sv/black_border_extent_finder_core_defines.svh
// ----------------------------------------------------------------------------
// Black border extent finder: assertion macros
// Shared check macros for the extent finder core, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef BLACK_BORDER_EXTENT_FINDER_CORE_DEFINES_SVH
`define BLACK_BORDER_EXTENT_FINDER_CORE_DEFINES_SVH

// Check that is masked while reset is asserted.
`define BBEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define BBEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/bbef_pkg.sv
// ----------------------------------------------------------------------------
// Black border extent finder package
// Widths, register indexes and dimension helpers shared by the core files.
// ----------------------------------------------------------------------------
package bbef_pkg;

  localparam int MaxDim  = 4096;
  localparam int PosW    = $clog2(MaxDim);   // column/row position
  localparam int DimW    = PosW + 1;         // dimension 1..MaxDim
  localparam int ChanW   = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = DimW;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  localparam logic [DimW-1:0] ResetWidth  = DimW'(1920);
  localparam logic [DimW-1:0] ResetHeight = DimW'(1080);

  // Effective dimension: register value clamped to 1..MaxDim.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  localparam logic [PosW-1:0] ResetHalfW = PosW'(clamp_dim(ResetWidth) >> 1);
  localparam logic [PosW-1:0] ResetHalfH = PosW'(clamp_dim(ResetHeight) >> 1);

endpackage

FILE: sv/bbef_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one BGR pixel per item.
// ----------------------------------------------------------------------------
interface bbef_pix_if import bbef_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

FILE: sv/bbef_rect_if.sv
// ----------------------------------------------------------------------------
// Rectangle channel
// Valid/ready channel carrying one content rectangle per item.
// ----------------------------------------------------------------------------
interface bbef_rect_if import bbef_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PosW-1:0] left;
  logic [PosW-1:0] top;
  logic [DimW-1:0] rect_width;
  logic [DimW-1:0] rect_height;

  modport source (output valid, output left, output top, output rect_width,
                  output rect_height, input ready);
  modport sink   (input valid, input left, input top, input rect_width,
                  input rect_height, output ready);
endinterface

FILE: sv/black_border_extent_finder_core.sv
// ----------------------------------------------------------------------------
// Black border extent finder core
// Tracks the non-black rectangle of a raster BGR frame from six sample lines.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, in raster order, and counts column and row
// itself from image_width / image_height (clamped to 1..4096; a write takes
// effect on the next pixel and must land between frames). Sample rows H/4,
// H/2, 3H/4 test blue, green, red and widen the left/right extents; sample
// columns W/4, W/2, 3W/4 do the same for top/bottom. Extents reload to the
// centre on the first pixel of every frame. On the last pixel one item
// (left, top, rect_width, rect_height) is loaded into the output register.
// Throughput is one pixel per cycle while pix_i.ready is high: the
// per-pixel update is a handful of compares, and a subtract and an add
// lie between the state registers and the output register. The result is
// registered and valid in the cycle after the last pixel. pix_i.ready drops
// only while a result sits in the output register and the sink stalls.
// ----------------------------------------------------------------------------
`include "black_border_extent_finder_core_defines.svh"

module black_border_extent_finder_core import bbef_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  bbef_pix_if.sink            pix_i,
  bbef_rect_if.source         rect_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration
  logic [DimW-1:0] width_q, height_q;

  // Raster position and extents
  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic [PosW-1:0] left_q, left_d, right_q, right_d;
  logic [PosW-1:0] top_q, top_d, bottom_q, bottom_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [PosW-1:0] out_left_q, out_top_q;
  logic [DimW-1:0] out_w_q, out_h_q;

  logic            pix_acc;
  logic            frame_start, frame_end, last_col, last_row;
  logic            b_nz, g_nz, r_nz, row_hit, col_hit;
  logic [DimW-1:0] w_eff, h_eff, w_half, h_half, w_qtr, h_qtr, w_3q, h_3q;
  logic [DimW+1:0] w_x3, h_x3;
  logic [DimW-1:0] x_ext, y_ext;
  logic [PosW-1:0] left_cur, right_cur, top_cur, bottom_cur;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample line positions (shifts and one add per dimension)
  // --------------------------------------------------------------------------
  always_comb begin
    w_eff  = clamp_dim(width_q);
    h_eff  = clamp_dim(height_q);
    w_half = w_eff >> 1;
    h_half = h_eff >> 1;
    w_qtr  = w_eff >> 2;
    h_qtr  = h_eff >> 2;
    w_x3   = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
    h_x3   = {2'b00, h_eff} + {1'b0, h_eff, 1'b0};
    w_3q   = w_x3[DimW+1:2];
    h_3q   = h_x3[DimW+1:2];
  end

  // --------------------------------------------------------------------------
  // Per-pixel update
  // --------------------------------------------------------------------------
  assign pix_i.ready = !out_valid_q || rect_o.ready;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  always_comb begin
    x_ext = {1'b0, col_q};
    y_ext = {1'b0, row_q};
    b_nz  = pix_i.blue  != '0;
    g_nz  = pix_i.green != '0;
    r_nz  = pix_i.red   != '0;

    // first pixel of a frame starts from the centre
    frame_start = (col_q == '0) && (row_q == '0);
    left_cur    = frame_start ? w_half[PosW-1:0] : left_q;
    right_cur   = frame_start ? w_half[PosW-1:0] : right_q;
    top_cur     = frame_start ? h_half[PosW-1:0] : top_q;
    bottom_cur  = frame_start ? h_half[PosW-1:0] : bottom_q;

    row_hit = (y_ext == h_qtr && b_nz) || (y_ext == h_half && g_nz) ||
              (y_ext == h_3q && r_nz);
    col_hit = (x_ext == w_qtr && b_nz) || (x_ext == w_half && g_nz) ||
              (x_ext == w_3q && r_nz);

    left_d   = (row_hit && col_q < left_cur)   ? col_q : left_cur;
    right_d  = (row_hit && col_q > right_cur)  ? col_q : right_cur;
    top_d    = (col_hit && row_q < top_cur)    ? row_q : top_cur;
    bottom_d = (col_hit && row_q > bottom_cur) ? row_q : bottom_cur;

    // counters at or past the end wrap, so a frame always terminates
    last_col  = x_ext >= (w_eff - DimW'(1));
    last_row  = y_ext >= (h_eff - DimW'(1));
    frame_end = last_col && last_row;

    col_d = last_col ? '0 : col_q + PosW'(1);
    row_d = row_q;
    if (last_col) begin
      row_d = last_row ? '0 : row_q + PosW'(1);
    end

    out_valid_d = out_valid_q && !rect_o.ready;
    if (pix_acc && frame_end) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= ResetHalfW;
      right_q     <= ResetHalfW;
      top_q       <= ResetHalfH;
      bottom_q    <= ResetHalfH;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pix_acc) begin
        col_q    <= col_d;
        row_q    <= row_d;
        left_q   <= left_d;
        right_q  <= right_d;
        top_q    <= top_d;
        bottom_q <= bottom_d;
      end
    end
  end

  // Result payload, loaded on the last pixel of a frame
  always_ff @(posedge clk_i) begin
    if (pix_acc && frame_end) begin
      out_left_q <= left_d;
      out_top_q  <= top_d;
      out_w_q    <= {1'b0, right_d} - {1'b0, left_d} + DimW'(1);
      out_h_q    <= {1'b0, bottom_d} - {1'b0, top_d} + DimW'(1);
    end
  end

  assign rect_o.valid       = out_valid_q;
  assign rect_o.left        = out_left_q;
  assign rect_o.top         = out_top_q;
  assign rect_o.rect_width  = out_w_q;
  assign rect_o.rect_height = out_h_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BBEF_ASSERT_ALWAYS(a_reset_clears_out, !rst_ni |=> !out_valid_q, "result valid after reset")
  `BBEF_ASSERT(a_extent_order, (left_q <= right_q) && (top_q <= bottom_q), "extents crossed")
  `BBEF_ASSERT(a_frame_end_result, (pix_acc && frame_end) |=> (out_valid_q && col_q == '0 && row_q == '0), "frame end did not post a result")
  `BBEF_ASSERT(a_stall_only_full, !pix_i.ready |-> (out_valid_q && !rect_o.ready), "input stalled with free output")
  `BBEF_ASSERT(a_rect_nonzero, out_valid_q |-> (out_w_q != '0 && out_h_q != '0), "empty rectangle reported")

endmodule
